// ===== rtl/bfha_pkg.sv =====
package bfha_pkg;

  localparam int unsigned HEAP_BYTES = 4096;
  localparam int unsigned WORDS      = HEAP_BYTES / 4;
  localparam int unsigned AW         = $clog2(WORDS);
  localparam int unsigned PW         = $clog2(HEAP_BYTES);
  localparam int unsigned DW         = 16;
  // Byte sums of a position and a block size need one bit beyond the size.
  localparam int unsigned SUMW       = DW + 1;
  localparam int unsigned NEEDW      = 14;
  localparam int unsigned GUARD_MAX  = 2 * WORDS + 2;
  localparam int unsigned GW         = $clog2(GUARD_MAX + 1);
  localparam logic [PW-1:0]   END_POS   = PW'(HEAP_BYTES - 4);
  localparam logic [SUMW-1:0] END_SUM   = SUMW'(HEAP_BYTES - 4);
  localparam logic [SUMW-1:0] HEAP_SUM  = SUMW'(HEAP_BYTES);
  localparam logic [DW-1:0]   END_MARK  = DW'(1);

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_COALESCE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_MISALIGN  = 3'd3,
    ST_OUTSIDE   = 3'd4,
    ST_WAS_FREE  = 3'd5
  } status_e;

  // Contents of a heap word just after reset.
  function automatic logic [DW-1:0] init_word(input logic [AW-1:0] addr);
    logic [DW-1:0] v;
    v = '0;
    if (addr == AW'(1)) begin
      v = DW'(HEAP_BYTES - 8) | DW'(2);
    end else if (addr == AW'(WORDS - 2)) begin
      v = DW'(HEAP_BYTES - 8);
    end else if (addr == AW'(WORDS - 1)) begin
      v = END_MARK;
    end
    return v;
  endfunction

endpackage

// ===== rtl/best_fit_heap_allocator_top.sv =====
// Best-fit heap allocator over an implicit block list held in a 1024 x 16 heap memory.
// A command beat is taken on a rising edge where start is high and busy is low:
// command_i selects allocate, free or coalesce, with request_size_i and
// payload_offset_i as operands. Exactly one result beat follows, shown on
// status_o, result_offset_o and merged_o for a single cycle while done_o is high.
// The receiver cannot stall, so the result must be captured in that cycle.
// A free checks the header, writes the footer and header, then clears the next block's
// flag; a free that fails its offset checks is answered from the idle state.
// Allocate walks the block headers, one memory read and one size compare per block,
// then writes the chosen header and either the remainder's header and footer or the
// next block's flag. Coalesce reads each visited block and its successor and writes a
// header and a footer for each merge. The time per command is therefore set by the
// heap memory, with one read port and one write port, and by the walk length.
// Busy stays high until the result beat, so only one command is in flight.
// After reset the block sweeps the whole heap memory, one word a cycle, writing
// one free block, its footer and the end mark; during this sweep busy is high and no
// command is accepted.
module best_fit_heap_allocator_top
  import bfha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       command_i,
  input  logic [12:0]      request_size_i,
  input  logic [11:0]      payload_offset_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [11:0]      result_offset_o,
  output logic             merged_o
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_CLEAR  = 17'h00002,
    S_A_RD   = 17'h00004,
    S_A_CHK  = 17'h00008,
    S_A_XN   = 17'h00010,
    S_A_FIN  = 17'h00020,
    S_A_S1   = 17'h00040,
    S_A_S2   = 17'h00080,
    S_F_RD   = 17'h00100,
    S_F_CHK  = 17'h00200,
    S_F_HDR  = 17'h00400,
    S_F_NRD  = 17'h00800,
    S_F_NCHK = 17'h01000,
    S_C_RD   = 17'h02000,
    S_C_H    = 17'h04000,
    S_C_N    = 17'h08000,
    S_C_FT   = 17'h10000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [PW-1:0]     best_q, best_d;
  logic [DW-1:0]     bsize_q, bsize_d;
  logic              have_q, have_d;
  logic              bprev_q, bprev_d;
  logic [NEEDW-1:0]  need_q, need_d;
  logic [DW-1:0]     h_q, h_d;
  logic [DW-1:0]     s_q, s_d;
  logic [GW-1:0]     guard_q, guard_d;
  logic              merged_q, merged_d;
  logic              done_q;
  logic [2:0]        status_q;
  logic [11:0]       res_q;
  logic              mres_q;

  logic              fin;
  status_e           fin_status;
  logic [11:0]       fin_res;
  logic              fin_merged;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DW-1:0]     wdata, rdata;

  // The header just read, its size and the byte position past its block.
  logic [DW-1:0]     rd_s;
  logic [SUMW-1:0]   pos_x, end_a, n_c, nend_c, best_x, need_x, hp_end;
  logic              stop_a, stop_n;
  logic [13:0]       need_c;
  logic [PW-1:0]     hp_c;

  bfha_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_s   = {rdata[DW-1:2], 2'b00};
  assign pos_x  = SUMW'(pos_q);
  assign best_x = SUMW'(best_q);
  assign need_x = SUMW'(need_q);
  assign end_a  = pos_x + SUMW'(rd_s);
  assign stop_a = (rdata == END_MARK) || (rd_s == '0) || (end_a > END_SUM);
  assign n_c    = pos_x + SUMW'(s_q);
  assign nend_c = n_c + SUMW'(rd_s);
  assign stop_n = (rdata == END_MARK) || (rd_s == '0) || (nend_c > END_SUM);
  // Rounded block size: request plus header, up to a multiple of eight.
  assign need_c = (14'(request_size_i) + 14'd11) & ~14'd7;
  assign hp_c   = payload_offset_i - 12'd4;
  assign hp_end = SUMW'(pos_q) + SUMW'(s_q);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    best_d     = best_q;
    bsize_d    = bsize_q;
    have_d     = have_q;
    bprev_d    = bprev_q;
    need_d     = need_q;
    h_d        = h_q;
    s_d        = s_q;
    guard_d    = guard_q;
    merged_d   = merged_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_res    = '0;
    fin_merged = 1'b0;
    we         = 1'b0;
    waddr      = pos_q[PW-1:2];
    wdata      = '0;
    raddr      = pos_q[PW-1:2];

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = init_word(clr_q);
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (cmd_e'(command_i))
            CMD_ALLOC: begin
              if (request_size_i == '0) begin
                fin        = 1'b1;
                fin_status = ST_BAD_SIZE;
              end else begin
                need_d  = need_c;
                pos_d   = PW'(4);
                have_d  = 1'b0;
                state_d = S_A_RD;
              end
            end
            CMD_FREE: begin
              if (payload_offset_i[2:0] != 3'd0) begin
                fin        = 1'b1;
                fin_status = ST_MISALIGN;
              end else if (payload_offset_i < 12'd8 ||
                           payload_offset_i > 12'(HEAP_BYTES - 8)) begin
                fin        = 1'b1;
                fin_status = ST_OUTSIDE;
              end else begin
                pos_d   = hp_c;
                state_d = S_F_RD;
              end
            end
            CMD_COALESCE: begin
              pos_d    = PW'(4);
              guard_d  = '0;
              merged_d = 1'b0;
              state_d  = S_C_RD;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Allocate: walk headers, keeping the smallest larger free block; an exact fit is taken at once.
      S_A_RD: begin
        if (pos_q >= END_POS) begin
          state_d = S_A_FIN;
        end else begin
          state_d = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (stop_a) begin
          state_d = S_A_FIN;
        end else if (!rdata[0] && SUMW'(rd_s) > need_x &&
                     (!have_q || rd_s < bsize_q)) begin
          best_d  = pos_q;
          bsize_d = rd_s;
          bprev_d = rdata[1];
          have_d  = 1'b1;
          pos_d   = end_a[PW-1:0];
          state_d = S_A_RD;
        end else if (!rdata[0] && SUMW'(rd_s) == need_x) begin
          we      = 1'b1;
          wdata   = DW'(need_q) | DW'(1) | (rdata & DW'(2));
          raddr   = end_a[AW+1:2];
          best_d  = pos_q;
          pos_d   = end_a[PW-1:0];
          state_d = S_A_XN;
        end else begin
          pos_d   = end_a[PW-1:0];
          state_d = S_A_RD;
        end
      end

      S_A_XN: begin
        if (rdata != END_MARK) begin
          we    = 1'b1;
          wdata = rdata | DW'(2);
        end
        fin     = 1'b1;
        fin_res = best_q + PW'(4);
      end

      S_A_FIN: begin
        if (have_q) begin
          we      = 1'b1;
          waddr   = best_q[PW-1:2];
          wdata   = DW'(need_q) | DW'(1) | {{(DW-2){1'b0}}, bprev_q, 1'b0};
          state_d = S_A_S1;
        end else begin
          fin        = 1'b1;
          fin_status = ST_NO_FIT;
        end
      end

      S_A_S1: begin
        we      = 1'b1;
        waddr   = AW'((best_x + need_x) >> 2);
        wdata   = (bsize_q - DW'(need_q)) | DW'(2);
        state_d = S_A_S2;
      end

      S_A_S2: begin
        we      = 1'b1;
        waddr   = AW'((best_x + SUMW'(bsize_q) - SUMW'(4)) >> 2);
        wdata   = bsize_q - DW'(need_q);
        fin     = 1'b1;
        fin_res = best_q + PW'(4);
      end

      // Free: header check, footer, header, then the next block's flag.
      S_F_RD: begin
        state_d = S_F_CHK;
      end

      S_F_CHK: begin
        if (!rdata[0]) begin
          fin        = 1'b1;
          fin_status = ST_WAS_FREE;
        end else begin
          h_d = rdata;
          s_d = rd_s;
          if (end_a - SUMW'(4) < HEAP_SUM) begin
            we    = 1'b1;
            waddr = AW'((end_a - SUMW'(4)) >> 2);
            wdata = rd_s;
          end
          state_d = S_F_HDR;
        end
      end

      S_F_HDR: begin
        we      = 1'b1;
        wdata   = s_q | (h_q & DW'(2));
        state_d = S_F_NRD;
      end

      S_F_NRD: begin
        raddr   = hp_end[AW+1:2];
        state_d = S_F_NCHK;
      end

      S_F_NCHK: begin
        if (hp_end < HEAP_SUM && rdata != END_MARK) begin
          we    = 1'b1;
          waddr = hp_end[AW+1:2];
          wdata = rdata & ~DW'(2);
        end
        fin = 1'b1;
      end

      // Coalesce: merge a free block with a free successor and retry in place, else move on.
      S_C_RD: begin
        if (pos_q >= END_POS || guard_q >= GW'(GUARD_MAX)) begin
          fin        = 1'b1;
          fin_merged = merged_q;
        end else begin
          guard_d = guard_q + GW'(1);
          state_d = S_C_H;
        end
      end

      S_C_H: begin
        if (stop_a) begin
          fin        = 1'b1;
          fin_merged = merged_q;
        end else begin
          h_d     = rdata;
          s_d     = rd_s;
          raddr   = end_a[AW+1:2];
          state_d = S_C_N;
        end
      end

      S_C_N: begin
        if (stop_n) begin
          fin        = 1'b1;
          fin_merged = merged_q;
        end else if (!h_q[0] && !rdata[0]) begin
          we      = 1'b1;
          wdata   = (s_q + rd_s) | (h_q & DW'(2));
          s_d     = s_q + rd_s;
          state_d = S_C_FT;
        end else if (rdata[0]) begin
          pos_d   = nend_c[PW-1:0];
          state_d = S_C_RD;
        end else begin
          pos_d   = n_c[PW-1:0];
          state_d = S_C_RD;
        end
      end

      S_C_FT: begin
        we       = 1'b1;
        waddr    = AW'((hp_end - SUMW'(4)) >> 2);
        wdata    = s_q;
        merged_d = 1'b1;
        state_d  = S_C_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      have_q   <= 1'b0;
      merged_q <= 1'b0;
      guard_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= fin;
      have_q   <= have_d;
      merged_q <= merged_d;
      guard_q  <= guard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    best_q  <= best_d;
    bsize_q <= bsize_d;
    bprev_q <= bprev_d;
    need_q  <= need_d;
    h_q     <= h_d;
    s_q     <= s_d;
    if (fin) begin
      status_q <= fin_status;
      res_q    <= fin_res;
      mres_q   <= fin_merged;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_offset_o = res_q;
  assign merged_o        = mres_q;

  // The heap is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("heap write while idle");

  // A failed command never reports an offset.
  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (result_offset_o == '0))
    else $error("offset on failed command");

  // A merge is only reported with a successful status and no offset.
  a_merge_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && merged_o) |-> (status_o == ST_OK && result_offset_o == '0))
    else $error("merge flag on wrong result");

  // The reset sweep ends in idle and never produces a result.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !done_o)
    else $error("result during heap clear");

endmodule

// ===== rtl/bfha_ram.sv =====
module bfha_ram
  import bfha_pkg::*;
(
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_best_fit_heap_allocator_top.sv =====
module tb_best_fit_heap_allocator_top;
  import bfha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BIG_SIZE = 1000000;
  localparam int unsigned HEAP_END = HEAP_BYTES - 4;

  typedef struct {
    cmd_e        cmd;
    logic [12:0] req;
    logic [11:0] off;
  } cmd_beat_t;

  typedef struct {
    status_e     status;
    logic [11:0] offset;
    logic        merged;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [12:0] request_size_i;
  logic [11:0] payload_offset_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [11:0] result_offset_o;
  logic        merged_o;

  best_fit_heap_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .result_offset_o  (result_offset_o),
    .merged_o         (merged_o)
  );

  // The predictor keeps its own image of the heap words.
  logic [15:0] heap_img [WORDS];
  cmd_beat_t   pending_cmds [$];
  reply_t      expected_replies [$];
  int unsigned live_payloads [$];
  int          errors;
  bit          stim_done;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reads beyond the heap give zero and writes there are dropped.
  function automatic int unsigned heap_rd(int unsigned pos);
    return ((pos >> 2) < WORDS) ? int'(heap_img[pos >> 2]) : 0;
  endfunction

  function automatic void heap_wr(int unsigned pos, int unsigned v);
    if ((pos >> 2) < WORDS) heap_img[pos >> 2] = v[15:0];
  endfunction

  // Size of the block whose header h sits at pos, or zero where a walk stops.
  function automatic int unsigned block_len(int unsigned pos, int unsigned h);
    int unsigned s;
    s = h & 16'hFFFC;
    if (h == 1 || s == 0 || pos + s > HEAP_END) return 0;
    return s;
  endfunction

  function automatic void heap_reset_image();
    foreach (heap_img[i]) heap_img[i] = '0;
    heap_wr(4, (HEAP_BYTES - 8) | 2);
    heap_wr(HEAP_END - 4, HEAP_BYTES - 8);
    heap_wr(HEAP_END, 1);
  endfunction

  function automatic reply_t predict_heap_op(cmd_beat_t c);
    reply_t r;
    int unsigned need, pos, best, best_size, h, s, nh, ns, hp, guard;
    bit have;
    r.status = ST_OK;
    r.offset = '0;
    r.merged = 1'b0;
    case (c.cmd)
      CMD_ALLOC: begin
        if (c.req == 0) begin
          r.status = ST_BAD_SIZE;
          return r;
        end
        need = (int'(c.req) + 11) & ~7;
        pos = 4;
        best = 0;
        best_size = BIG_SIZE;
        have = 0;
        while (pos < HEAP_END) begin
          h = heap_rd(pos);
          s = block_len(pos, h);
          if (s == 0) break;
          if (!h[0]) begin
            if (s > need && s < best_size) begin
              best_size = s;
              best = pos;
              have = 1;
            end else if (s == need) begin
              heap_wr(pos, need | 1 | (h & 2));
              nh = heap_rd(pos + s);
              if (nh != 1 && ((pos + s) >> 2) < WORDS) heap_wr(pos + s, nh | 2);
              r.offset = 12'(pos + 4);
              return r;
            end
          end
          pos += s;
        end
        if (have) begin
          h = heap_rd(best);
          heap_wr(best, need | 1 | (h & 2));
          heap_wr(best + need, (best_size - need) | 2);
          heap_wr(best + best_size - 4, best_size - need);
          r.offset = 12'(best + 4);
        end else begin
          r.status = ST_NO_FIT;
        end
      end
      CMD_FREE: begin
        if (c.off[2:0] != 0) begin
          r.status = ST_MISALIGN;
          return r;
        end
        if (c.off < 8 || c.off > HEAP_BYTES - 8) begin
          r.status = ST_OUTSIDE;
          return r;
        end
        hp = int'(c.off) - 4;
        h = heap_rd(hp);
        if (!h[0]) begin
          r.status = ST_WAS_FREE;
          return r;
        end
        s = h & 16'hFFFC;
        heap_wr(hp + s - 4, s);
        heap_wr(hp, s | (h & 2));
        nh = heap_rd(hp + s);
        if (nh != 1 && ((hp + s) >> 2) < WORDS) heap_wr(hp + s, nh & ~2);
      end
      CMD_COALESCE: begin
        pos = 4;
        guard = 0;
        while (pos < HEAP_END && guard < GUARD_MAX) begin
          guard++;
          h = heap_rd(pos);
          s = block_len(pos, h);
          if (s == 0) break;
          nh = heap_rd(pos + s);
          ns = block_len(pos + s, nh);
          if (ns == 0) break;
          if (!h[0] && !nh[0]) begin
            heap_wr(pos, (s + ns) | (h & 2));
            heap_wr(pos + s + ns - 4, s + ns);
            r.merged = 1'b1;
          end else if (nh[0]) begin
            pos = pos + s + ns;
          end else begin
            pos = pos + s;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(cmd_e cmd, int unsigned req, int unsigned off);
    cmd_beat_t c;
    c.cmd = cmd;
    c.req = 13'(req);
    c.off = 12'(off);
    pending_cmds.push_back(c);
  endfunction

  // Driver: one command beat per handshake, with a random gap drawn per beat.
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= CMD_ALLOC;
      request_size_i <= '0;
      payload_offset_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        // The beat has just been taken, so its result is predicted now.
        expected_replies.push_back(predict_heap_op('{cmd_e'(command_i),
                                                     request_size_i,
                                                     payload_offset_i}));
      end
      if (start && busy) begin
        // Keep the current beat steady until it is taken.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0 && !hold_off) begin
        cmd_beat_t c;
        c = pending_cmds.pop_front();
        start <= 1'b1;
        command_i <= c.cmd;
        request_size_i <= c.req;
        payload_offset_i <= c.off;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so each strobed beat is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: result beat with no expectation, got status %0d offset %0d merged %0d",
                 $time, status_o, result_offset_o, merged_o);
        errors++;
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (result_offset_o !== e.offset) begin
          $display("%0t: result_offset expected %0d actual %0d", $time, e.offset,
                   result_offset_o);
          errors++;
        end
        if (merged_o !== e.merged) begin
          $display("%0t: merged expected %0d actual %0d", $time, e.merged, merged_o);
          errors++;
        end
        // Track live payloads so that later frees hit real blocks.
        if (e.status == ST_OK && e.offset != 0) live_payloads.push_back(e.offset);
      end
    end
  end

  // Stimulus: a directed opening, then mostly allocate and free of live blocks.
  initial begin
    int unsigned k, pick, choice;
    errors = 0;
    stim_done = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    heap_reset_image();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b0;
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero request, the largest request, an exact fit of the whole heap.
    queue_cmd(CMD_ALLOC, 0, 0);
    queue_cmd(CMD_ALLOC, 4096, 0);
    queue_cmd(CMD_ALLOC, 8191, 0);
    queue_cmd(CMD_ALLOC, HEAP_BYTES - 12, 0);
    queue_cmd(CMD_ALLOC, 1, 0);
    queue_cmd(CMD_FREE, 8, 0);
    queue_cmd(CMD_FREE, 8, 0);
    queue_cmd(CMD_COALESCE, 0, 0);
    // Splits, a free in the middle, and the free-check failures in order.
    queue_cmd(CMD_ALLOC, 1, 0);
    queue_cmd(CMD_ALLOC, 12, 0);
    queue_cmd(CMD_ALLOC, 100, 0);
    queue_cmd(CMD_FREE, 16, 0);
    queue_cmd(CMD_FREE, 3, 0);
    queue_cmd(CMD_FREE, 4095, 0);
    queue_cmd(CMD_FREE, 0, 0);
    queue_cmd(CMD_FREE, 4088, 0);
    queue_cmd(CMD_FREE, 4080, 0);
    queue_cmd(CMD_FREE, 2048, 0);
    queue_cmd(CMD_NONE, 8191, 4095);
    queue_cmd(CMD_ALLOC, 4, 0);
    queue_cmd(CMD_FREE, 8, 0);
    queue_cmd(CMD_FREE, 32, 0);
    queue_cmd(CMD_COALESCE, 0, 0);
    queue_cmd(CMD_COALESCE, 0, 0);

    // Sampled at the falling edge, once the driver's updates have settled.
    while (pending_cmds.size() != 0 || expected_replies.size() != 0 || start)
      @(negedge clk_i);

    // Pause the sender while the first random command is queued, then send the random part.
    hold_off = 1;
    for (k = 0; k < 1430; k++) begin
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        pick = $urandom_range(0, 7);
        queue_cmd(CMD_ALLOC, (pick == 0) ? $urandom_range(0, 8191) :
                  (pick == 1) ? $urandom_range(400, 4096) : $urandom_range(1, 120), 0);
      end else if (choice < 80 && live_payloads.size() != 0) begin
        pick = $urandom_range(0, live_payloads.size() - 1);
        queue_cmd(CMD_FREE, 0, live_payloads[pick]);
        live_payloads.delete(pick);
      end else if (choice < 90) begin
        queue_cmd(CMD_COALESCE, 0, 0);
      end else if (choice < 98) begin
        queue_cmd(CMD_FREE, 0, $urandom_range(0, 4095));
      end else begin
        queue_cmd(CMD_NONE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end
      if (k == 0) hold_off = 0;
      // Feed in step with the driver so live payloads stay current.
      while (pending_cmds.size() > 1) @(posedge clk_i);
    end
    stim_done = 1;
  end

  // End of run: all beats taken, every expectation met, then a short drain.
  initial begin
    wait (stim_done);
    while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
      @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
